>>> rtl/core/handle_heap_allocator_compactor_core_assert.svh
// assertion macros used by the checker file
`ifndef HANDLE_HEAP_ALLOCATOR_COMPACTOR_CORE_ASSERT_SVH
`define HANDLE_HEAP_ALLOCATOR_COMPACTOR_CORE_ASSERT_SVH
// property that must hold at every edge out of reset
`define HH_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication whose consequent is checked in the next cycle
`define HH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/core/hhac_pkg.sv
// types and constants for the handle heap allocator core
package hhac_pkg;
    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_REALLOC = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;
    localparam logic [1:0] REQ_LOOKUP  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_HANDLE = 2'd1;
    localparam logic [1:0] ST_NO_SPACE  = 2'd2;
    localparam logic [1:0] ST_BAD       = 2'd3;

    localparam logic CFG_DATA_BYTES   = 1'b0;
    localparam logic CFG_HANDLE_COUNT = 1'b1;

    localparam int REFS_W = 16;

    localparam int MAX_HANDLES = 64;
    localparam int HEAP_BYTES  = 4096;
    localparam int WORD_BYTES  = 4;
    localparam int HDR_BYTES   = 16;
    localparam int WB_SH       = $clog2(WORD_BYTES);
    localparam int SZ_W        = $clog2(HEAP_BYTES) + 6;
endpackage

>>> rtl/core/hhac_size.sv
// object byte size from type and element count
module hhac_size (
    input  logic [3:0]                i_type,
    input  logic [12:0]               i_count,
    output logic [hhac_pkg::SZ_W-1:0] o_bytes
);
    import hhac_pkg::*;

    logic [SZ_W-1:0] w_b;
    logic [SZ_W-1:0] w_words;
    always_comb begin
        if (i_type <= 4'd2) begin
            w_b = SZ_W'(i_count) * SZ_W'(WORD_BYTES);
        end else begin
            w_b = SZ_W'(i_count);
        end
        w_words = (w_b + SZ_W'(WORD_BYTES - 1)) >> WB_SH;
        o_bytes = SZ_W'(HDR_BYTES) + (w_words << WB_SH);
    end
endmodule

>>> rtl/core/handle_heap_allocator_compactor_core.sv
// top level of the handle based compacting heap allocator
// channel  direction  ports                                        beat
// config   in         i_cfg_we i_cfg_index i_cfg_data             i_cfg_we high
// request  in         i_start i_req_type i_obj_type i_elem_count  start and not busy
//                     i_handle_in
// result   out        o_done o_status o_handle_out o_data_offset  o_done high
//                     o_compacted
// lookup, release and requests refused in S_RRD pass S_HRD, S_RRD and S_OUT before the next accept
// an alloc adds S_CHK and S_APP and a realloc also S_KILL, reading and writing back both memories
// a compaction adds S_CRD and S_CWR per object record walked and a second pass through S_CHK
// config writes and reset clear every handle table entry with busy high
// the result strobe lasts one cycle, the first cycle with busy low
module handle_heap_allocator_compactor_core #(
    parameter int MAX_OBJECTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        i_start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [3:0]  i_obj_type,
    input  logic [12:0] i_elem_count,
    input  logic [5:0]  i_handle_in,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [5:0]  o_handle_out,
    output logic [11:0] o_data_offset,
    output logic        o_compacted
);
    import hhac_pkg::*;

    localparam int HW   = $clog2(MAX_HANDLES);
    localparam int OW   = $clog2(MAX_OBJECTS);
    localparam int OTW  = OW + 1;
    localparam int HCW  = HW + 1;
    localparam int FPW  = SZ_W;

    typedef struct packed {
        logic [HW-1:0]     handle;
        logic [3:0]        otype;
        logic [12:0]       count;
        logic [REFS_W-1:0] refs;
        logic              live;
    } t_rec;

    typedef struct packed {
        logic [FPW-1:0] offset;
        logic [OW-1:0]  rec;
        logic [HCW-1:0] link;
        logic           live;
    } t_hent;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HRD   = 4'd2;
    localparam logic [3:0] S_RRD   = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_CRD   = 4'd5;
    localparam logic [3:0] S_CWR   = 4'd6;
    localparam logic [3:0] S_KILL  = 4'd7;
    localparam logic [3:0] S_APP   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    t_hent r_hmem [MAX_HANDLES];
    t_rec  r_omem [MAX_OBJECTS];

    logic [3:0]        r_state;
    logic [12:0]       r_data_bytes;
    logic [6:0]        r_handle_count;
    logic [HCW-1:0]    r_head;
    logic [OTW-1:0]    r_total;
    logic [FPW-1:0]    r_fill;
    logic [HW-1:0]     r_clr;
    logic [1:0]        r_req;
    logic [3:0]        r_type;
    logic [12:0]       r_count;
    logic [5:0]        r_hin;
    logic [HW-1:0]     r_h;
    logic              r_cmp;
    logic              r_did_cmp;
    logic [OTW-1:0]    r_ci;
    logic [OW-1:0]     r_ck;
    logic [FPW-1:0]    r_cnext;
    logic [REFS_W-1:0] r_refs;
    logic [OW-1:0]     r_oldrec;
    t_hent             r_hent;
    logic              r_done;
    logic [1:0]        r_status;
    logic [5:0]        r_hout;
    logic [11:0]       r_off;

    logic            hwe;
    logic [HW-1:0]   hwa;
    t_hent           hwd;
    logic [HW-1:0]   hra;
    t_hent           r_hrd;
    logic            owe;
    logic [OW-1:0]   owa;
    t_rec            owd;
    logic [OW-1:0]   ora;
    t_rec            r_ord;

    always_ff @(posedge i_clk) begin
        if (hwe) begin
            r_hmem[hwa] <= hwd;
        end
        r_hrd <= r_hmem[hra];
        if (owe) begin
            r_omem[owa] <= owd;
        end
        r_ord <= r_omem[ora];
    end

    logic [SZ_W-1:0] need;
    logic [SZ_W-1:0] csz;
    hhac_size u_need (.i_type(r_type), .i_count(r_count), .o_bytes(need));
    hhac_size u_csz (.i_type(r_ord.otype), .i_count(r_ord.count), .o_bytes(csz));

    logic [HCW:0]    eff_h;
    logic [FPW-1:0]  cap;
    logic            fits;
    logic            hbad;
    logic [FPW-1:0]  pay;
    always_comb begin
        eff_h = (HCW+1)'(r_handle_count) < (HCW+1)'(MAX_HANDLES)
              ? (HCW+1)'(r_handle_count) : (HCW+1)'(MAX_HANDLES);
        cap = FPW'(r_data_bytes) < FPW'(HEAP_BYTES) ? FPW'(r_data_bytes) : FPW'(HEAP_BYTES);
        fits = (r_fill <= cap) && ((cap - r_fill) >= need)
            && (r_total < OTW'(MAX_OBJECTS));
        hbad = ((HCW+1)'(r_hin) >= eff_h);
        pay = r_fill + FPW'(HDR_BYTES);
    end

    logic [HCW-1:0] head_rst;
    always_comb begin
        head_rst = (eff_h == '0) ? '1 : HCW'(eff_h - 1'b1);
    end

    always_comb begin
        hwe = 1'b0; hwa = r_h; hwd = r_hent;
        owe = 1'b0; owa = r_ck; owd = r_ord;
        hra = r_h; ora = r_ci[OW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                hwe = 1'b1; hwa = r_clr;
                hwd = '{offset: '0, rec: '0,
                        link: (r_clr == '0) ? '1 : HCW'(r_clr - HW'(1)), live: 1'b0};
            end
            S_IDLE: begin
                hra = (i_req_type == REQ_ALLOC) ? r_head[HW-1:0] : HW'(i_handle_in);
            end
            S_HRD: begin
                ora = r_hrd.rec;
            end
            S_RRD: begin
                if (r_req == REQ_RELEASE && !hbad && r_hent.live) begin
                    owe = 1'b1; owa = r_hent.rec; owd = r_ord;
                    owd.refs = r_ord.refs - REFS_W'(1);
                    owd.live = (r_ord.refs != REFS_W'(1));
                    if (r_ord.refs == REFS_W'(1)) begin
                        hwe = 1'b1; hwa = r_h; hwd = r_hent;
                        hwd.link = r_head;
                        hwd.live = 1'b0;
                    end
                end
            end
            S_CRD: begin
                ora = r_ci[OW-1:0];
            end
            S_CWR: begin
                if (r_ord.live) begin
                    owe = 1'b1; owa = r_ck; owd = r_ord;
                    hwe = 1'b1; hwa = r_ord.handle;
                    hwd = '{offset: r_cnext + FPW'(HDR_BYTES), rec: r_ck,
                            link: '0, live: 1'b1};
                end
            end
            S_KILL: begin
                owe = 1'b1; owa = r_oldrec;
                owd = '{handle: r_h, otype: r_type, count: r_count,
                        refs: r_refs, live: 1'b0};
            end
            S_APP: begin
                owe = 1'b1; owa = r_total[OW-1:0];
                owd = '{handle: r_h, otype: r_type, count: r_count,
                        refs: r_refs, live: 1'b1};
                hwe = 1'b1; hwa = r_h;
                hwd = '{offset: pay, rec: r_total[OW-1:0], link: r_hent.link, live: 1'b1};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_data_bytes <= 13'd4096;
            r_handle_count <= 7'd64;
            r_head <= HCW'(MAX_HANDLES - 1);
            r_total <= '0;
            r_fill <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_DATA_BYTES) r_data_bytes <= i_cfg_data;
                else r_handle_count <= i_cfg_data[6:0];
                r_state <= S_CLEAR;
                r_clr <= '0;
                r_total <= '0;
                r_fill <= '0;
                r_head <= '1;
            end else begin
                unique case (r_state)
                    S_CLEAR: begin
                        r_clr <= r_clr + HW'(1);
                        r_head <= head_rst;
                        if (r_clr == HW'(MAX_HANDLES - 1)) r_state <= S_IDLE;
                    end
                    S_IDLE: begin
                        if (i_start) begin
                            r_req <= i_req_type; r_type <= i_obj_type;
                            r_count <= i_elem_count; r_hin <= i_handle_in;
                            r_h <= (i_req_type == REQ_ALLOC) ? r_head[HW-1:0]
                                                             : HW'(i_handle_in);
                            r_refs <= REFS_W'(1);
                            r_did_cmp <= 1'b0;
                            r_state <= S_HRD;
                        end
                    end
                    S_HRD: begin
                        r_hent <= r_hrd;
                        r_state <= S_RRD;
                    end
                    S_RRD: begin
                        r_hout <= r_hin; r_off <= '0; r_status <= ST_OK;
                        r_state <= S_OUT;
                        if (r_req == REQ_ALLOC) begin
                            if (r_head >= HCW'(MAX_HANDLES)) begin
                                r_status <= ST_NO_HANDLE;
                            end else begin
                                r_state <= S_CHK;
                            end
                        end else if (hbad || !r_hent.live) begin
                            r_status <= ST_BAD;
                        end else if (r_req == REQ_LOOKUP) begin
                            r_off <= r_hent.offset[11:0];
                        end else if (r_req == REQ_REALLOC) begin
                            r_type <= r_ord.otype; r_refs <= r_ord.refs;
                            r_oldrec <= r_hent.rec;
                            r_off <= r_hent.offset[11:0];
                            r_state <= S_CHK;
                        end else if (r_ord.refs == REFS_W'(1)) begin
                            r_head <= HCW'(r_h);
                        end
                    end
                    S_CHK: begin
                        if (fits) begin
                            r_state <= (r_req == REQ_REALLOC) ? S_KILL : S_APP;
                        end else if (!r_did_cmp) begin
                            r_did_cmp <= 1'b1;
                            r_ci <= '0; r_ck <= '0; r_cnext <= '0;
                            r_state <= (r_total == '0) ? S_CHK : S_CRD;
                            if (r_total == '0) begin
                                r_fill <= '0;
                            end
                        end else begin
                            r_status <= ST_NO_SPACE;
                            r_state <= S_OUT;
                        end
                    end
                    S_CRD: r_state <= S_CWR;
                    S_CWR: begin
                        if (r_ord.live) begin
                            r_ck <= r_ck + OW'(1);
                            r_cnext <= r_cnext + csz;
                            if (r_ord.handle == r_h && r_req == REQ_REALLOC) begin
                                r_oldrec <= r_ck;
                                r_off <= 12'(r_cnext + FPW'(HDR_BYTES));
                            end
                        end
                        r_ci <= r_ci + OTW'(1);
                        if (r_ci + OTW'(1) == r_total) begin
                            r_total <= r_ord.live ? OTW'(r_ck) + OTW'(1) : OTW'(r_ck);
                            r_fill <= r_ord.live ? r_cnext + csz : r_cnext;
                            r_state <= S_CHK;
                        end else begin
                            r_state <= S_CRD;
                        end
                    end
                    S_KILL: r_state <= S_APP;
                    S_APP: begin
                        if (r_req == REQ_ALLOC) begin
                            r_head <= r_hent.link;
                            r_hout <= 6'(r_h);
                        end
                        r_off <= pay[11:0];
                        r_total <= r_total + OTW'(1);
                        r_fill <= r_fill + need;
                        r_state <= S_OUT;
                    end
                    S_OUT: begin
                        r_done <= 1'b1;
                        r_cmp <= r_did_cmp;
                        r_state <= S_IDLE;
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_handle_out  = r_hout;
    assign o_data_offset = r_off;
    assign o_compacted   = r_cmp;
endmodule

>>> rtl/core/hhac_checker.sv
// port level checks for the heap allocator core
`include "handle_heap_allocator_compactor_core_assert.svh"
module hhac_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        busy,
    input logic        o_done,
    input logic [1:0]  o_status,
    input logic [11:0] o_data_offset,
    input logic        o_compacted
);
    import hhac_pkg::*;
    `HH_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done, "done held two cycles")
    `HH_ASSERT_NEXT(a_busy_after, i_clk, i_rst_n, i_start && !busy, busy, "no busy after start")
    `HH_ASSERT_ALWAYS(a_bad_zero, i_clk, i_rst_n,
        !(o_done && o_status == ST_BAD) || o_data_offset == '0, "bad handle offset")
    `HH_ASSERT_ALWAYS(a_nh_nocmp, i_clk, i_rst_n,
        !(o_done && o_status == ST_NO_HANDLE) || !o_compacted, "compaction without handle")
endmodule

bind handle_heap_allocator_compactor_core hhac_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .busy(busy),
    .o_done(o_done), .o_status(o_status), .o_data_offset(o_data_offset),
    .o_compacted(o_compacted));
